// ----- hw/rtl/rsc_pkg.sv -----
// Shared types, codes and pixel conversion for the RGBI scanline pixel composer.
package rsc_pkg;

  // Result source codes
  localparam logic [1:0] KIND_BLACK   = 2'd0;
  localparam logic [1:0] KIND_SCREEN  = 2'd1;
  localparam logic [1:0] KIND_OVERLAY = 2'd2;

  // RGBI level for a lit channel, with and without intensity
  localparam logic [7:0] LEVEL_BRIGHT = 8'd255;
  localparam logic [7:0] LEVEL_NORMAL = 8'd170;

  // RGB332 field masks
  localparam logic [7:0] MASK_R = 8'he0;
  localparam logic [7:0] MASK_G = 8'h1c;
  localparam logic [7:0] MASK_B = 8'h03;

  // Entries of the classify-to-render queue
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    REG_MARGIN_WORDS       = 3'd0,
    REG_VISIBLE_WORDS      = 3'd1,
    REG_OVERLAY_ON         = 3'd2,
    REG_OVERLAY_FULL_WIDTH = 3'd3,
    REG_OVERLAY_COL_START  = 3'd4,
    REG_OVERLAY_COL_END    = 3'd5,
    REG_OVERLAY_ROW_START  = 3'd6,
    REG_OVERLAY_ROW_END    = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [10:0] word_pos;
    logic [8:0]  source_row;
    logic [7:0]  screen_byte;
    logic [7:0]  overlay_byte;
  } rsc_in_t;

  typedef struct packed {
    logic [31:0] pixel_word;
    logic [1:0]  source_kind;
    logic [16:0] screen_addr;
    logic [15:0] overlay_addr;
  } rsc_out_t;

  typedef struct packed {
    logic [7:0] margin_words;
    logic [9:0] visible_words;
    logic       overlay_on;
    logic       overlay_full_width;
    logic [9:0] overlay_col_start;
    logic [9:0] overlay_col_end;
    logic [8:0] overlay_row_start;
    logic [8:0] overlay_row_end;
  } rsc_cfg_t;

  // Classified position, handed from front to back
  typedef struct packed {
    logic       visible;
    logic [1:0] kind;
    logic [9:0] col;
    logic [8:0] row;
    logic [9:0] col_off;
    logic [8:0] row_off;
    logic [7:0] data;
  } rsc_item_t;

  function automatic logic [7:0] nibble_to_rgb332(input logic [3:0] nib);
    logic [7:0] lv;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    lv = nib[3] ? LEVEL_BRIGHT : LEVEL_NORMAL;
    r  = nib[2] ? lv : 8'd0;
    g  = nib[1] ? lv : 8'd0;
    b  = nib[0] ? lv : 8'd0;
    return (r & MASK_R) | ((g >> 3) & MASK_G) | ((b >> 6) & MASK_B);
  endfunction

  function automatic logic [31:0] byte_to_word(input logic [7:0] data);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = nibble_to_rgb332(data[3:0]);
    hi = nibble_to_rgb332(data[7:4]);
    return {hi, hi, lo, lo};
  endfunction

endpackage

// ----- hw/rtl/rsc_front.sv -----
// Front end: accepts positions, classifies margin, screen, overlay or blanked.
module rsc_front (
  input  logic             in_push,
  output logic             in_full,
  input  rsc_pkg::rsc_in_t in_item,
  input  rsc_pkg::rsc_cfg_t cfg,
  output logic             q_push,
  output rsc_pkg::rsc_item_t q_item,
  input  logic             q_full
);
  import rsc_pkg::*;

  logic [10:0] vis_end;
  logic [10:0] x_full;
  logic        in_vis;
  logic        orow;
  logic        ocol;

  assign in_full = q_full;
  assign q_push  = in_push && !q_full;

  always_comb begin
    vis_end = 11'(cfg.margin_words) + 11'(cfg.visible_words);
    x_full  = in_item.word_pos - 11'(cfg.margin_words);
    in_vis  = (in_item.word_pos >= 11'(cfg.margin_words)) && (in_item.word_pos < vis_end);
    orow    = cfg.overlay_on &&
              (in_item.source_row >= cfg.overlay_row_start) &&
              (in_item.source_row < cfg.overlay_row_end);
    ocol    = (x_full[9:0] >= cfg.overlay_col_start) && (x_full[9:0] < cfg.overlay_col_end);

    q_item.visible = in_vis;
    q_item.col     = x_full[9:0];
    q_item.row     = in_item.source_row;
    q_item.col_off = x_full[9:0] - cfg.overlay_col_start;
    q_item.row_off = in_item.source_row - cfg.overlay_row_start;
    q_item.data    = in_item.screen_byte;
    if (!in_vis) begin
      q_item.kind = KIND_BLACK;
    end else if (orow && ocol) begin
      q_item.kind = KIND_OVERLAY;
      q_item.data = in_item.overlay_byte;
    end else if (orow && cfg.overlay_full_width) begin
      q_item.kind = KIND_BLACK;
    end else begin
      q_item.kind = KIND_SCREEN;
    end
  end

endmodule

// ----- hw/rtl/rsc_queue.sv -----
// Short queue of classified positions between front and back.
module rsc_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rsc_pkg::rsc_item_t push_item,
  output logic               full,
  input  logic               pop,
  output rsc_pkg::rsc_item_t pop_item,
  output logic               valid
);
  import rsc_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  rsc_item_t          mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push;
  logic               do_pop;

  assign full     = (count_r == CNT_W'(QUEUE_DEPTH));
  assign valid    = (count_r != '0);
  assign pop_item = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- hw/rtl/rsc_back.sv -----
// Back end: renders pixels and addresses into the output register.
module rsc_back #(
  parameter int SCREEN_ROW_BYTES  = 256,
  parameter int OVERLAY_ROW_BYTES = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  rsc_pkg::rsc_item_t q_item,
  output logic               q_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output rsc_pkg::rsc_out_t  out_item
);
  import rsc_pkg::*;

  localparam logic [16:0] SROW_C = 17'(SCREEN_ROW_BYTES);
  localparam logic [15:0] OROW_C = 16'(OVERLAY_ROW_BYTES);

  logic      out_valid_r, out_valid_nxt;
  rsc_out_t  out_r;
  rsc_out_t  res;

  assign q_pop     = q_valid && (!out_valid_r || out_pop);
  assign out_empty = !out_valid_r;
  assign out_item  = out_r;

  always_comb begin
    res.pixel_word   = (q_item.kind == KIND_BLACK) ? 32'd0 : byte_to_word(q_item.data);
    res.source_kind  = q_item.kind;
    res.screen_addr  = q_item.visible ? (17'(q_item.row) * SROW_C + 17'(q_item.col)) : 17'd0;
    res.overlay_addr = (q_item.kind == KIND_OVERLAY) ?
                       (16'(q_item.row_off) * OROW_C + 16'(q_item.col_off)) : 16'd0;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_r <= res;
    end
  end

endmodule

// ----- hw/rtl/rgbi_scanline_pixel_composer.sv -----
// Top level of the RGBI scanline pixel composer: config registers, front, queue, back.
//
// Usage:
//   Input side looks like a queue: drive in_item and raise in_push; a
//   transaction completes on a clock edge with in_push high and in_full low.
//   Each transaction names one word position of a scanline (margin, visible,
//   margin) with its source row and the screen and overlay bytes.
//   Result side looks like a queue too: while out_empty is low the oldest
//   result sits on out_item; it is taken on an edge with out_pop high.
//   Exactly one result per input transaction, in order.
// Throughput: one transaction per cycle on both sides while out_pop stays
//   high, set by the combinational classify stage and the render stage.
// Path: an accepted item is written into the queue and then into the output
//   register, where it sits on out_item with out_empty low, if nothing waits ahead.
// Stall: while out_pop is low the output register holds; the two-entry queue
//   between classify and render keeps absorbing items, and in_full rises
//   once it fills.
// Reset (rst_n low, synchronous): queue and output emptied, all config
//   registers cleared. Config writes (cfg_valid, always ready) are to be
//   issued only while the block is drained.
module rgbi_scanline_pixel_composer #(
  parameter int SCREEN_ROW_BYTES  = 256,
  parameter int OVERLAY_ROW_BYTES = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  rsc_pkg::rsc_in_t  in_item,
  output logic              out_empty,
  input  logic              out_pop,
  output rsc_pkg::rsc_out_t out_item,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  rsc_pkg::cfg_idx_t cfg_index,
  input  logic [15:0]       cfg_data
);
  import rsc_pkg::*;

  rsc_cfg_t  cfg_r, cfg_nxt;
  logic      q_push;
  logic      q_full;
  logic      q_valid;
  logic      q_pop;
  rsc_item_t q_in_item;
  rsc_item_t q_out_item;

  // Config registers: always ready, one register per transaction.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_MARGIN_WORDS:       cfg_nxt.margin_words       = cfg_data[7:0];
        REG_VISIBLE_WORDS:      cfg_nxt.visible_words      = cfg_data[9:0];
        REG_OVERLAY_ON:         cfg_nxt.overlay_on         = cfg_data[0];
        REG_OVERLAY_FULL_WIDTH: cfg_nxt.overlay_full_width = cfg_data[0];
        REG_OVERLAY_COL_START:  cfg_nxt.overlay_col_start  = cfg_data[9:0];
        REG_OVERLAY_COL_END:    cfg_nxt.overlay_col_end    = cfg_data[9:0];
        REG_OVERLAY_ROW_START:  cfg_nxt.overlay_row_start  = cfg_data[8:0];
        REG_OVERLAY_ROW_END:    cfg_nxt.overlay_row_end    = cfg_data[8:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Classify at the input, straight into the queue.
  rsc_front u_front (
    .in_push (in_push),
    .in_full (in_full),
    .in_item (in_item),
    .cfg     (cfg_r),
    .q_push  (q_push),
    .q_item  (q_in_item),
    .q_full  (q_full)
  );

  rsc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_out_item),
    .valid     (q_valid)
  );

  // Render pixels and addresses into the output register.
  rsc_back #(
    .SCREEN_ROW_BYTES  (SCREEN_ROW_BYTES),
    .OVERLAY_ROW_BYTES (OVERLAY_ROW_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_out_item),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

// ----- hw/rtl/rsc_checker.sv -----
// Port-level checker for the pixel composer, bound to the top level.
module rsc_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_push,
  input logic              in_full,
  input logic              out_empty,
  input logic              out_pop,
  input rsc_pkg::rsc_out_t out_item
);
  import rsc_pkg::*;

  // Reset drains the result side.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result side not empty after reset");

  // A held result does not change.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_item)))
    else $error("stalled result changed or vanished");

  // An accepted transaction is followed by a non-empty result side.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full) |=> ##1 !out_empty)
    else $error("accepted transaction produced no result");

  // Only three source codes exist.
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_item.source_kind == KIND_BLACK ||
                    out_item.source_kind == KIND_SCREEN ||
                    out_item.source_kind == KIND_OVERLAY))
    else $error("bad source kind");

  // Overlay address is zero unless the overlay byte was used.
  a_oaddr: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_item.source_kind != KIND_OVERLAY) |-> out_item.overlay_addr == 16'd0)
    else $error("overlay address set on non-overlay result");

endmodule

bind rgbi_scanline_pixel_composer rsc_checker u_rsc_checker (.*);
